// ===== sv/scp_pkg.sv =====
package scp_pkg;

   // Port payload widths.
   localparam int LON_W      = 26;
   localparam int LAT_W      = 24;
   localparam int REQ_W      = 56;
   localparam int RADIUS_W   = 24;
   localparam int OFFSET_W   = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Internal number formats.
   localparam int ANG_W  = 27;   // angle in Q17 degrees, signed
   localparam int MAG_W  = 31;   // magnitude of a Q30 sine or cosine
   localparam int SC_W   = 32;   // signed Q30 sine or cosine
   localparam int NUM_W  = 56;   // dividend and quotient of the radius division
   localparam int DEN_W  = 31;   // divisor of the radius division
   localparam int PROD_W = 58;   // scaled coordinate magnitude
   localparam int WIDE_W = 64;   // signed coordinate before clamping

   localparam int DEG45_Q17  = 5898240;
   localparam int DEG90_Q17  = 11796480;
   localparam int DEG180_Q17 = 23592960;
   localparam int DEG270_Q17 = 35389440;
   localparam int DEG360_Q17 = 47185920;
   localparam int ONE_Q30    = 1 << 30;

   localparam int RADIUS_DEFAULT = 3754936;

   // Pipeline depths of the units.
   localparam int SC_LAT   = 16;
   localparam int DIV_LAT  = NUM_W + 1;
   localparam int OUT_LAT  = 4;
   localparam int PIPE_LAT = SC_LAT + DIV_LAT + OUT_LAT;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_SAT     = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RADIUS   = 2'd0,
      CSR_OFFSET_X = 2'd1,
      CSR_OFFSET_Y = 2'd2
   } csr_type;

   typedef struct packed {
      logic neg;
      logic invalid;
   } flags_type;

endpackage

// ===== sv/scp_sincos.sv =====
module scp_sincos (
   input  logic                             clock,
   input  logic                             en,
   input  logic signed [scp_pkg::ANG_W-1:0] angle,
   output logic signed [scp_pkg::SC_W-1:0]  sine,
   output logic signed [scp_pkg::SC_W-1:0]  cosine
);
   import scp_pkg::*;

   localparam int RED_W     = 26;
   localparam int RES_W     = 24;
   localparam int FOLD_W    = 23;
   localparam int X_W       = 30;
   localparam int T_W       = 31;
   localparam int RAD_W     = 50;
   localparam int SQ_W      = 2 * X_W;
   localparam int STEP_W    = X_W + MAG_W;
   localparam int SIN_STEPS = 5;
   localparam int COS_STEPS = 6;
   localparam logic [26:0] RAD_PER_DEG = 27'd74961321;
   localparam logic [RAD_W-1:0] RAD_RND = RAD_W'(1) << 18;

   localparam int SIN_SHIFT [SIN_STEPS] = '{37, 37, 36, 35, 33};
   localparam int COS_SHIFT [COS_STEPS] = '{38, 37, 36, 35, 34, 31};
   // Reciprocals rounded up: exact quotients for any dividend below 2^30.
   localparam logic [MAG_W-1:0] SIN_MAGIC [SIN_STEPS] = '{
      MAG_W'((64'd1 << 37) / 64'd110 + 64'd1),
      MAG_W'((64'd1 << 37) / 64'd72 + 64'd1),
      MAG_W'((64'd1 << 36) / 64'd42 + 64'd1),
      MAG_W'((64'd1 << 35) / 64'd20 + 64'd1),
      MAG_W'((64'd1 << 33) / 64'd6 + 64'd1)
   };
   localparam logic [MAG_W-1:0] COS_MAGIC [COS_STEPS] = '{
      MAG_W'((64'd1 << 38) / 64'd132 + 64'd1),
      MAG_W'((64'd1 << 37) / 64'd90 + 64'd1),
      MAG_W'((64'd1 << 36) / 64'd56 + 64'd1),
      MAG_W'((64'd1 << 35) / 64'd30 + 64'd1),
      MAG_W'((64'd1 << 34) / 64'd12 + 64'd1),
      MAG_W'((64'd1 << 31) / 64'd2 + 64'd1)
   };

   typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_type;

   typedef struct packed {
      quad_type quad;
      logic     swap;
   } ctl_type;

   logic signed [ANG_W:0] a_ext, a_plus, a_plus2, a_minus;
   logic [RED_W-1:0]      red_in, red_ff;
   logic [RES_W-1:0]      res;
   logic [FOLD_W-1:0]     fold_in, fold_ff;
   ctl_type               ctl_in;
   ctl_type               ctl_ff [2:15];
   logic [RAD_W-1:0]      rad;
   logic [SQ_W-1:0]       sq;
   logic [X_W-1:0]        x_in, x2_in;
   logic [X_W-1:0]        x_ff [3:13];
   logic [X_W-1:0]        x2_ff [4:13];
   logic [STEP_W-1:0]     first_s, first_c;
   logic [STEP_W-1:0]     mul_s [1:5];
   logic [STEP_W-1:0]     mul_c [1:5];
   logic [STEP_W-1:0]     div_s [1:4];
   logic [STEP_W-1:0]     div_c [1:5];
   logic [X_W-1:0]        ps_in [1:5];
   logic [X_W-1:0]        pc_in [1:5];
   logic [X_W-1:0]        ps_ff [1:5];
   logic [X_W-1:0]        pc_ff [1:5];
   logic [T_W-1:0]        ts_in [1:5];
   logic [T_W-1:0]        tc_in [1:6];
   logic [T_W-1:0]        ts_ff [1:5];
   logic [T_W-1:0]        tc_ff [1:6];
   logic [X_W-1:0]        sn_ff;
   logic signed [SC_W-1:0] su, cu, sine_in, cosine_in, sine_ff, cosine_ff;

   // Range reduction to [0, 360) degrees.
   always_comb begin
      a_ext   = (ANG_W + 1)'(angle);
      a_plus  = a_ext + (ANG_W + 1)'(DEG360_Q17);
      a_plus2 = a_ext + (ANG_W + 1)'(2 * DEG360_Q17);
      a_minus = a_ext - (ANG_W + 1)'(DEG360_Q17);
      if (a_ext < 0) begin
         red_in = (a_plus < 0) ? RED_W'(a_plus2) : RED_W'(a_plus);
      end else if (a_ext >= (ANG_W + 1)'(DEG360_Q17)) begin
         red_in = RED_W'(a_minus);
      end else begin
         red_in = RED_W'(a_ext);
      end
   end

   // Quadrant split and fold to at most 45 degrees.
   always_comb begin
      if (red_ff >= RED_W'(DEG270_Q17)) begin
         ctl_in.quad = QUAD_3;
         res         = RES_W'(red_ff - RED_W'(DEG270_Q17));
      end else if (red_ff >= RED_W'(DEG180_Q17)) begin
         ctl_in.quad = QUAD_2;
         res         = RES_W'(red_ff - RED_W'(DEG180_Q17));
      end else if (red_ff >= RED_W'(DEG90_Q17)) begin
         ctl_in.quad = QUAD_1;
         res         = RES_W'(red_ff - RED_W'(DEG90_Q17));
      end else begin
         ctl_in.quad = QUAD_0;
         res         = RES_W'(red_ff);
      end
      ctl_in.swap = (res > RES_W'(DEG45_Q17));
      fold_in = ctl_in.swap ? FOLD_W'(RES_W'(DEG90_Q17) - res) : FOLD_W'(res);
   end

   // Degrees to radians, then the square.
   always_comb begin
      rad   = RAD_W'(fold_ff) * RAD_W'(RAD_PER_DEG) + RAD_RND;
      x_in  = X_W'(rad >> 19);
      sq    = SQ_W'(x_ff[3]) * SQ_W'(x_ff[3]);
      x2_in = X_W'(sq >> 30);
   end

   // Horner steps: a multiply stage and a reciprocal stage each.
   always_comb begin
      first_s  = STEP_W'(x2_ff[4]) * STEP_W'(SIN_MAGIC[0]);
      first_c  = STEP_W'(x2_ff[4]) * STEP_W'(COS_MAGIC[0]);
      ts_in[1] = T_W'(ONE_Q30) - T_W'(first_s >> SIN_SHIFT[0]);
      tc_in[1] = T_W'(ONE_Q30) - T_W'(first_c >> COS_SHIFT[0]);
      for (int k = 1; k <= 5; k++) begin
         // The last sine step multiplies by x to finish the odd series.
         mul_s[k] = (k == 5) ? STEP_W'(x_ff[13]) * STEP_W'(ts_ff[k])
                             : STEP_W'(x2_ff[3 + 2 * k]) * STEP_W'(ts_ff[k]);
         mul_c[k] = STEP_W'(x2_ff[3 + 2 * k]) * STEP_W'(tc_ff[k]);
         ps_in[k] = X_W'(mul_s[k] >> 30);
         pc_in[k] = X_W'(mul_c[k] >> 30);
      end
      for (int k = 1; k <= 4; k++) begin
         div_s[k]     = STEP_W'(ps_ff[k]) * STEP_W'(SIN_MAGIC[k]);
         ts_in[k + 1] = T_W'(ONE_Q30) - T_W'(div_s[k] >> SIN_SHIFT[k]);
      end
      for (int k = 1; k <= 5; k++) begin
         div_c[k]     = STEP_W'(pc_ff[k]) * STEP_W'(COS_MAGIC[k]);
         tc_in[k + 1] = T_W'(ONE_Q30) - T_W'(div_c[k] >> COS_SHIFT[k]);
      end
   end

   // Undo the fold and place the result in its quadrant.
   always_comb begin
      su = ctl_ff[15].swap ? SC_W'(tc_ff[6]) : SC_W'(sn_ff);
      cu = ctl_ff[15].swap ? SC_W'(sn_ff) : SC_W'(tc_ff[6]);
      case (ctl_ff[15].quad)
         QUAD_0: begin
            sine_in   = su;
            cosine_in = cu;
         end
         QUAD_1: begin
            sine_in   = cu;
            cosine_in = -su;
         end
         QUAD_2: begin
            sine_in   = -su;
            cosine_in = -cu;
         end
         default: begin
            sine_in   = -cu;
            cosine_in = su;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         red_ff    <= red_in;
         fold_ff   <= fold_in;
         ctl_ff[2] <= ctl_in;
         for (int i = 3; i <= 15; i++) begin
            ctl_ff[i] <= ctl_ff[i - 1];
         end
         x_ff[3] <= x_in;
         for (int i = 4; i <= 13; i++) begin
            x_ff[i] <= x_ff[i - 1];
         end
         x2_ff[4] <= x2_in;
         for (int i = 5; i <= 13; i++) begin
            x2_ff[i] <= x2_ff[i - 1];
         end
         for (int k = 1; k <= 5; k++) begin
            ts_ff[k] <= ts_in[k];
            ps_ff[k] <= ps_in[k];
            pc_ff[k] <= pc_in[k];
         end
         for (int k = 1; k <= 6; k++) begin
            tc_ff[k] <= tc_in[k];
         end
         sn_ff     <= ps_ff[5];
         sine_ff   <= sine_in;
         cosine_ff <= cosine_in;
      end
   end

   assign sine   = sine_ff;
   assign cosine = cosine_ff;

endmodule

// ===== sv/scp_div.sv =====
module scp_div (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [scp_pkg::SC_W-1:0]     sine,
   input  logic signed [scp_pkg::SC_W-1:0]     cosine,
   input  logic        [scp_pkg::RADIUS_W-1:0] radius,
   output logic        [scp_pkg::NUM_W-1:0]    quotient,
   output scp_pkg::flags_type                  flags
);
   import scp_pkg::*;

   localparam int STAGES = NUM_W;

   logic [MAG_W-1:0]  sa_mag, ca_mag;
   logic [NUM_W-1:0]  num;
   logic [DEN_W:0]    trial [1:STAGES];
   logic              ge [1:STAGES];
   logic [DEN_W-1:0]  rem_in [1:STAGES];
   logic [NUM_W-1:0]  qr_in [1:STAGES];
   logic [DEN_W-1:0]  rem_ff [0:STAGES];
   logic [NUM_W-1:0]  qr_ff [0:STAGES];
   logic [DEN_W-1:0]  den_ff [0:STAGES-1];
   flags_type         flags_in;
   flags_type         flags_ff [0:STAGES];

   // Dividend is 2*r0*|sin| plus half the divisor, so the quotient rounds half up.
   always_comb begin
      sa_mag           = (sine < 0) ? MAG_W'(-sine) : MAG_W'(sine);
      ca_mag           = (cosine < 0) ? MAG_W'(-cosine) : MAG_W'(cosine);
      num              = NUM_W'({radius, 1'b0}) * NUM_W'(sa_mag);
      flags_in.neg     = sine[SC_W-1] ^ cosine[SC_W-1];
      flags_in.invalid = (cosine == '0);
   end

   // One quotient bit per stage; dividend bits leave at the top as
   // quotient bits enter at the bottom.
   always_comb begin
      for (int j = 1; j <= STAGES; j++) begin
         trial[j]  = {rem_ff[j - 1], qr_ff[j - 1][NUM_W-1]};
         ge[j]     = (trial[j] >= {1'b0, den_ff[j - 1]});
         rem_in[j] = ge[j] ? DEN_W'(trial[j] - {1'b0, den_ff[j - 1]}) : DEN_W'(trial[j]);
         qr_in[j]  = {qr_ff[j - 1][NUM_W-2:0], ge[j]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]   <= '0;
         qr_ff[0]    <= num + NUM_W'(ca_mag >> 1);
         den_ff[0]   <= DEN_W'(ca_mag);
         flags_ff[0] <= flags_in;
         for (int j = 1; j <= STAGES; j++) begin
            rem_ff[j]   <= rem_in[j];
            qr_ff[j]    <= qr_in[j];
            flags_ff[j] <= flags_ff[j - 1];
         end
         for (int j = 1; j < STAGES; j++) begin
            den_ff[j] <= den_ff[j - 1];
         end
      end
   end

   assign quotient = qr_ff[STAGES];
   assign flags    = flags_ff[STAGES];

endmodule

// ===== sv/scp_out.sv =====
module scp_out #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                en,
   input  logic        [scp_pkg::NUM_W-1:0]    radius,
   input  scp_pkg::flags_type                  flags,
   input  logic signed [scp_pkg::SC_W-1:0]     sine,
   input  logic signed [scp_pkg::SC_W-1:0]     cosine,
   input  logic signed [scp_pkg::OFFSET_W-1:0] offset_x,
   input  logic signed [scp_pkg::OFFSET_W-1:0] offset_y,
   output logic        [COORD_WIDTH-1:0]       plane_x,
   output logic        [COORD_WIDTH-1:0]       plane_y,
   output scp_pkg::status_type                 status
);
   import scp_pkg::*;

   localparam int LO_W   = 30;
   localparam int HI_W   = NUM_W - LO_W;
   localparam int LOP_W  = LO_W + MAG_W;
   localparam logic [LOP_W-1:0] HALF = LOP_W'(1) << 29;
   localparam logic signed [WIDE_W-1:0] COORD_MAX = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
   localparam logic signed [WIDE_W-1:0] COORD_MIN = -COORD_MAX - 64'sd1;

   logic [MAG_W-1:0]  sl_mag, cl_mag;
   logic [PROD_W-1:0] hx_in, hy_in, hx_ff, hy_ff;
   logic [LOP_W-1:0]  lx_in, ly_in, lx_ff, ly_ff;
   logic              negx_in, negy_in;
   logic              negx_ff [1:2];
   logic              negy_ff [1:2];
   logic              inv_ff [1:3];
   logic [PROD_W-1:0] mx_in, my_in, mx_ff, my_ff;
   logic signed [WIDE_W-1:0] vx_in, vy_in, vx_ff, vy_ff;
   logic              satx, saty;
   logic signed [WIDE_W-1:0] cx, cy;
   logic [COORD_WIDTH-1:0] px_in, py_in, px_ff, py_ff;
   status_type        status_in, status_ff;

   // The radius is split at bit 30 so each partial product stays narrow.
   always_comb begin
      sl_mag  = (sine < 0) ? MAG_W'(-sine) : MAG_W'(sine);
      cl_mag  = (cosine < 0) ? MAG_W'(-cosine) : MAG_W'(cosine);
      hx_in   = PROD_W'(radius[NUM_W-1:LO_W]) * PROD_W'(sl_mag);
      hy_in   = PROD_W'(radius[NUM_W-1:LO_W]) * PROD_W'(cl_mag);
      lx_in   = LOP_W'(radius[LO_W-1:0]) * LOP_W'(sl_mag);
      ly_in   = LOP_W'(radius[LO_W-1:0]) * LOP_W'(cl_mag);
      negx_in = flags.neg ^ sine[SC_W-1];
      negy_in = ~(flags.neg ^ cosine[SC_W-1]);
   end

   always_comb begin
      mx_in = hx_ff + PROD_W'((lx_ff + HALF) >> 30);
      my_in = hy_ff + PROD_W'((ly_ff + HALF) >> 30);
      vx_in = (negx_ff[2] ? -WIDE_W'(mx_ff) : WIDE_W'(mx_ff)) - WIDE_W'(offset_x);
      vy_in = (negy_ff[2] ? -WIDE_W'(my_ff) : WIDE_W'(my_ff)) - WIDE_W'(offset_y);
   end

   always_comb begin
      satx = 1'b0;
      saty = 1'b0;
      cx   = vx_ff;
      cy   = vy_ff;
      if (vx_ff > COORD_MAX) begin
         cx   = COORD_MAX;
         satx = 1'b1;
      end else if (vx_ff < COORD_MIN) begin
         cx   = COORD_MIN;
         satx = 1'b1;
      end
      if (vy_ff > COORD_MAX) begin
         cy   = COORD_MAX;
         saty = 1'b1;
      end else if (vy_ff < COORD_MIN) begin
         cy   = COORD_MIN;
         saty = 1'b1;
      end
      if (inv_ff[3]) begin
         px_in     = '0;
         py_in     = '0;
         status_in = STATUS_INVALID;
      end else begin
         px_in     = COORD_WIDTH'(cx);
         py_in     = COORD_WIDTH'(cy);
         status_in = (satx || saty) ? STATUS_SAT : STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hx_ff      <= hx_in;
         hy_ff      <= hy_in;
         lx_ff      <= lx_in;
         ly_ff      <= ly_in;
         negx_ff[1] <= negx_in;
         negy_ff[1] <= negy_in;
         negx_ff[2] <= negx_ff[1];
         negy_ff[2] <= negy_ff[1];
         inv_ff[1]  <= flags.invalid;
         inv_ff[2]  <= inv_ff[1];
         inv_ff[3]  <= inv_ff[2];
         mx_ff      <= mx_in;
         my_ff      <= my_in;
         vx_ff      <= vx_in;
         vy_ff      <= vy_in;
         px_ff      <= px_in;
         py_ff      <= py_in;
         status_ff  <= status_in;
      end
   end

   assign plane_x = px_ff;
   assign plane_y = py_ff;
   assign status  = status_ff;

endmodule

// ===== sv/stereographic_projection.sv =====
// Throughput: one item per cycle while the pipeline is not stalled; the radius
// division is a 56-stage pipeline that produces one quotient bit per stage.
// The pipeline stalls only while its last stage holds an item and the
// output register is full and not being taken.
// Synchronous active-high reset empties the pipeline and loads r0 = 180/pi and zero offsets.
module stereographic_projection #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // longitude [25:0], latitude [49:26], zero fill above
   input  logic [scp_pkg::REQ_W-1:0]              req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // plane_x, plane_y, status from the lowest bit up, zero fill above
   output logic [((2*COORD_WIDTH+2+7)/8)*8-1:0]   rsp_tdata,
   input  logic                                   csr_we,
   input  logic [scp_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [scp_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import scp_pkg::*;

   localparam int RSP_W = ((2 * COORD_WIDTH + 2 + 7) / 8) * 8;
   localparam logic [COORD_WIDTH-1:0] PX_MAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
   localparam logic [COORD_WIDTH-1:0] PX_MIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

   logic                       en;
   logic [PIPE_LAT:1]          vld_ff;
   logic signed [LON_W-1:0]    lon;
   logic signed [LAT_W-1:0]    lat;
   logic signed [ANG_W-1:0]    lat_ang, lon_ang;
   logic signed [ANG_W-1:0]    lon_dly_ff [0:DIV_LAT-1];
   logic [RADIUS_W-1:0]        radius_ff, r0;
   logic signed [OFFSET_W-1:0] offx_ff, offy_ff;
   logic signed [SC_W-1:0]     sa, ca, sl, cl;
   logic [NUM_W-1:0]           rmag;
   flags_type                  flags;
   logic [COORD_WIDTH-1:0]     px, py, rsp_px_ff, rsp_py_ff;
   status_type                 status, rsp_status_ff;
   logic                       rsp_valid_ff;

   assign en         = !vld_ff[PIPE_LAT] || !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   assign lon     = $signed(req_tdata[LON_W-1:0]);
   assign lat     = $signed(req_tdata[LON_W+LAT_W-1:LON_W]);
   // Longitude doubled into Q17; tangent angle is 45 degrees minus half the latitude.
   assign lon_ang = {lon, 1'b0};
   assign lat_ang = ANG_W'(DEG45_Q17) - ANG_W'(lat);
   assign r0      = (radius_ff == '0) ? RADIUS_W'(RADIUS_DEFAULT) : radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_W'(RADIUS_DEFAULT);
         offx_ff   <= '0;
         offy_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RADIUS:   radius_ff <= csr_wdata[RADIUS_W-1:0];
            CSR_OFFSET_X: offx_ff   <= $signed(csr_wdata[OFFSET_W-1:0]);
            CSR_OFFSET_Y: offy_ff   <= $signed(csr_wdata[OFFSET_W-1:0]);
            default: ;
         endcase
      end
   end

   // The longitude waits out the division so both halves meet at the output unit.
   always_ff @(posedge clock) begin
      if (en) begin
         lon_dly_ff[0] <= lon_ang;
         for (int i = 1; i < DIV_LAT; i++) begin
            lon_dly_ff[i] <= lon_dly_ff[i - 1];
         end
      end
   end

   scp_sincos u_lat_sincos (
      .clock  (clock),
      .en     (en),
      .angle  (lat_ang),
      .sine   (sa),
      .cosine (ca)
   );

   scp_div u_div (
      .clock    (clock),
      .en       (en),
      .sine     (sa),
      .cosine   (ca),
      .radius   (r0),
      .quotient (rmag),
      .flags    (flags)
   );

   scp_sincos u_lon_sincos (
      .clock  (clock),
      .en     (en),
      .angle  (lon_dly_ff[DIV_LAT-1]),
      .sine   (sl),
      .cosine (cl)
   );

   scp_out #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_out (
      .clock    (clock),
      .en       (en),
      .radius   (rmag),
      .flags    (flags),
      .sine     (sl),
      .cosine   (cl),
      .offset_x (offx_ff),
      .offset_y (offy_ff),
      .plane_x  (px),
      .plane_y  (py),
      .status   (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en) begin
            vld_ff <= {vld_ff[PIPE_LAT-1:1], req_tvalid};
         end
         if (en && vld_ff[PIPE_LAT]) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en && vld_ff[PIPE_LAT]) begin
         rsp_px_ff     <= px;
         rsp_py_ff     <= py;
         rsp_status_ff <= status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_status_ff, rsp_py_ff, rsp_px_ff});

   a_stall_keeps_item: assert property (@(posedge clock) disable iff (reset)
      vld_ff[PIPE_LAT] && !req_tready |=> vld_ff[PIPE_LAT])
      else $error("item at the pipeline end lost during a stall");

   a_invalid_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STATUS_INVALID |-> rsp_px_ff == '0 && rsp_py_ff == '0)
      else $error("invalid point with non-zero coordinates");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STATUS_SAT |->
         rsp_px_ff == PX_MAX || rsp_px_ff == PX_MIN ||
         rsp_py_ff == PX_MAX || rsp_py_ff == PX_MIN)
      else $error("saturated status without a clamped coordinate");

endmodule

// ===== test/stereographic_projection_checker.sv =====
`timescale 1ns / 1ps

module stereographic_projection_checker #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   // longitude [25:0], latitude [49:26], zero fill above
   input  logic [scp_pkg::REQ_W-1:0]            req_tdata,
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // plane_x, plane_y, status from the lowest bit up, zero fill above
   input  logic [((2*COORD_WIDTH+2+7)/8)*8-1:0] rsp_tdata,
   input  logic                                 csr_we,
   input  logic [scp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [scp_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output int                                   fail_count,
   output int                                   pending,
   output int                                   points_checked,
   output int                                   invalid_seen,
   output int                                   saturated_seen
);
   import scp_pkg::*;

   typedef struct {
      logic [COORD_WIDTH-1:0] plane_x;
      logic [COORD_WIDTH-1:0] plane_y;
      status_type             status;
   } point_type;

   point_type             projected_q[$];
   logic [RADIUS_W-1:0]   radius_reg;
   logic [OFFSET_W-1:0]   offset_x_reg;
   logic [OFFSET_W-1:0]   offset_y_reg;

   // Truncated Taylor series for an angle folded into [0, 45] degrees.
   function automatic void series_sincos(input longint unsigned v,
                                         output longint unsigned sn,
                                         output longint unsigned cs);
      longint unsigned one = 64'd1 << 30;
      longint unsigned sdiv[5] = '{110, 72, 42, 20, 6};
      longint unsigned cdiv[6] = '{132, 90, 56, 30, 12, 2};
      longint unsigned x, x2, t;
      x  = (v * 64'd74961321 + (64'd1 << 18)) >> 19;
      x2 = (x * x) >> 30;
      t  = one;
      for (int i = 0; i < 5; i++) t = one - ((x2 * t) >> 30) / sdiv[i];
      sn = (x * t) >> 30;
      t  = one;
      for (int i = 0; i < 6; i++) t = one - ((x2 * t) >> 30) / cdiv[i];
      cs = t;
   endfunction

   function automatic void angle_sincos(input longint ang, output longint sn,
                                        output longint cs);
      longint m, q, u, su, cu;
      longint unsigned ps, pc;
      m = ang % DEG360_Q17;
      if (m < 0) m += DEG360_Q17;
      q = m / DEG90_Q17;
      u = m - q * DEG90_Q17;
      if (u > DEG45_Q17) begin
         series_sincos(DEG90_Q17 - u, ps, pc);
         su = pc;
         cu = ps;
      end else begin
         series_sincos(u, ps, pc);
         su = ps;
         cu = pc;
      end
      case (q)
         0: begin sn = su;  cs = cu;  end
         1: begin sn = cu;  cs = -su; end
         2: begin sn = -su; cs = -cu; end
         default: begin sn = -cu; cs = su; end
      endcase
   endfunction

   function automatic longint unsigned magnitude(input longint v);
      return (v < 0) ? longint'(-v) : v;
   endfunction

   function automatic longint unsigned scale_q30(input longint unsigned mag,
                                                 input longint unsigned frac);
      return (mag >> 30) * frac + ((((mag & ((64'd1 << 30) - 1)) * frac)
             + (64'd1 << 29)) >> 30);
   endfunction

   function automatic longint clamp(input longint v, inout logic sat);
      longint hi = (longint'(1) << (COORD_WIDTH - 1)) - 1;
      if (v > hi) begin
         sat = 1'b1;
         return hi;
      end
      if (v < -hi - 1) begin
         sat = 1'b1;
         return -hi - 1;
      end
      return v;
   endfunction

   function automatic point_type project(input logic [LON_W-1:0] lon_bits,
                                         input logic [LAT_W-1:0] lat_bits);
      point_type p;
      longint lon, lat, sl, cl, sa, ca, xv, yv;
      longint unsigned r0, num, den, rmag;
      logic rneg, sat;
      lon = longint'($signed(lon_bits)) * 2;
      lat = longint'($signed(lat_bits));
      angle_sincos(lon, sl, cl);
      angle_sincos(DEG45_Q17 - lat, sa, ca);
      if (ca == 0) begin
         p.plane_x = '0;
         p.plane_y = '0;
         p.status  = STATUS_INVALID;
         return p;
      end
      r0   = (radius_reg != 0) ? radius_reg : RADIUS_DEFAULT;
      num  = 2 * r0 * magnitude(sa);
      den  = magnitude(ca);
      rmag = (num + den / 2) / den;
      rneg = (sa < 0) != (ca < 0);
      xv = scale_q30(rmag, magnitude(sl));
      yv = scale_q30(rmag, magnitude(cl));
      if (rneg != (sl < 0)) xv = -xv;
      if (rneg == (cl < 0)) yv = -yv;
      xv -= longint'($signed(offset_x_reg));
      yv -= longint'($signed(offset_y_reg));
      sat = 1'b0;
      xv = clamp(xv, sat);
      yv = clamp(yv, sat);
      p.plane_x = xv[COORD_WIDTH-1:0];
      p.plane_y = yv[COORD_WIDTH-1:0];
      p.status  = sat ? STATUS_SAT : STATUS_OK;
      return p;
   endfunction

   always @(posedge clock) begin
      point_type want;
      logic [COORD_WIDTH-1:0] got_x, got_y;
      logic [1:0] got_status;
      if (reset) begin
         radius_reg     <= RADIUS_W'(RADIUS_DEFAULT);
         offset_x_reg   <= '0;
         offset_y_reg   <= '0;
         fail_count     <= 0;
         points_checked <= 0;
         invalid_seen   <= 0;
         saturated_seen <= 0;
         pending        <= 0;
         projected_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_RADIUS:   radius_reg   <= csr_wdata[RADIUS_W-1:0];
               CSR_OFFSET_X: offset_x_reg <= csr_wdata;
               CSR_OFFSET_Y: offset_y_reg <= csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            projected_q.insert(projected_q.size(),
                               project(req_tdata[LON_W-1:0],
                                       req_tdata[LON_W+LAT_W-1:LON_W]));
         if (rsp_tvalid && rsp_tready) begin
            got_x      = rsp_tdata[COORD_WIDTH-1:0];
            got_y      = rsp_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
            got_status = rsp_tdata[2*COORD_WIDTH+1:2*COORD_WIDTH];
            if (projected_q.size() == 0) begin
               $display("%0t: result with no item outstanding: x %h y %h status %0d",
                        $time, got_x, got_y, got_status);
               fail_count <= fail_count + 1;
            end else begin
               want = projected_q.pop_front();
               points_checked <= points_checked + 1;
               if (want.status == STATUS_INVALID) invalid_seen <= invalid_seen + 1;
               if (want.status == STATUS_SAT) saturated_seen <= saturated_seen + 1;
               if (got_x !== want.plane_x || got_y !== want.plane_y ||
                   got_status !== want.status) begin
                  $display("%0t: plane_x expected %h actual %h", $time,
                           want.plane_x, got_x);
                  $display("%0t: plane_y expected %h actual %h", $time,
                           want.plane_y, got_y);
                  $display("%0t: status expected %0d actual %0d", $time,
                           want.status, got_status);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= projected_q.size();
      end
   end

endmodule

// ===== test/stereographic_projection_test.sv =====
`timescale 1ns / 1ps

module stereographic_projection_test;
   import scp_pkg::*;

   localparam int COORD_WIDTH = 32;
   localparam int RSP_W = ((2*COORD_WIDTH+2+7)/8)*8;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 100;
   localparam int ITEMS_PER_PHASE = 170;
   localparam int HOLD_AT = 200;
   localparam int HOLD_CYCLES = 1000;

   // Angles in the input format, 16 fraction bits.
   localparam int Q16_45 = 2949120;
   localparam int Q16_90 = 5898240;
   localparam int Q16_360 = 23592960;
   localparam int LON_TOP = (1 << 25) - 1;
   localparam int LON_BOTTOM = -(1 << 25);
   localparam int LAT_TOP = (1 << 23) - 1;
   localparam int LAT_BOTTOM = -(1 << 23);

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_W-1:0]       req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_W-1:0]       rsp_tdata;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int fail_count, pending, points_checked, invalid_seen, saturated_seen;
   int points_sent = 0;
   int points_taken = 0;
   int settings_used = 1;
   int quiet_cycles = 0;

   always #1 clock = ~clock;

   stereographic_projection #(.COORD_WIDTH(COORD_WIDTH)) dut (.*);

   stereographic_projection_checker #(.COORD_WIDTH(COORD_WIDTH)) u_checker (.*);

   task automatic offer_point(input int lon, input int lat);
      logic [LON_W-1:0] lon_bits = lon[LON_W-1:0];
      logic [LAT_W-1:0] lat_bits = lat[LAT_W-1:0];
      int gap;
      gap = ((points_sent / 64) % 4 == 2) ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W-LON_W-LAT_W){1'b0}}, lat_bits, lon_bits};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      points_sent++;
   endtask

   task automatic offer_random_point();
      int pick = $urandom_range(0, 99);
      int lon, lat;
      lon = $urandom_range(0, 2 * Q16_360) - Q16_360;
      lat = $urandom_range(0, 2 * Q16_90) - Q16_90;
      if (pick < 12)
         lat = -Q16_90 + $urandom_range(0, 64);      // close to the south pole
      else if (pick < 16)
         lat = -Q16_90;
      else if (pick < 40) begin
         lon = $urandom;                             // any bit pattern at all
         lat = $urandom;
      end
      offer_point(lon, lat);
   endtask

   // The block is idle only once every result is back and the pipeline is flushed.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_registers(input logic [31:0] radius, input logic [31:0] off_x,
                                 input logic [31:0] off_y);
      csr_we    <= 1'b1;
      csr_index <= CSR_RADIUS;
      csr_wdata <= radius;
      @(posedge clock);
      csr_index <= CSR_OFFSET_X;
      csr_wdata <= off_x;
      @(posedge clock);
      csr_index <= CSR_OFFSET_Y;
      csr_wdata <= off_y;
      @(posedge clock);
      // A write to the unused index must change nothing.
      csr_index <= CSR_SPARE;
      csr_wdata <= $urandom;
      @(posedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic run_random(input int count);
      repeat (count) offer_random_point();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      offer_point(0, 0);
      offer_point(LON_TOP, 0);
      offer_point(LON_BOTTOM, 0);
      offer_point(Q16_360, Q16_90);
      offer_point(-Q16_360, -Q16_90);
      offer_point(0, -Q16_90);
      offer_point(2 * Q16_90, -Q16_90 + 1);
      offer_point(4 * Q16_90, LAT_TOP);
      offer_point(-4 * Q16_90, LAT_BOTTOM);
      offer_point(Q16_45, Q16_45);
      offer_point(3 * Q16_45, -Q16_45);
      offer_point(LON_TOP, LAT_TOP);
      offer_point(LON_BOTTOM, LAT_BOTTOM);
      offer_point(6 * Q16_90, 1);
      offer_point(-1, -1);
      offer_point(1, Q16_90 - 1);
      offer_point(Q16_45 + 1, -Q16_90 + 1);
      offer_point(Q16_360 + Q16_45, 2 * Q16_90);
      run_random(ITEMS_PER_PHASE);

      wait_idle();
      load_registers(32'd0, 32'd0, 32'd0);
      run_random(ITEMS_PER_PHASE);

      wait_idle();
      load_registers(32'd1, 32'h8000_0000, 32'h7FFF_FFFF);
      run_random(ITEMS_PER_PHASE);

      wait_idle();
      load_registers(32'h00FF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      run_random(ITEMS_PER_PHASE);

      wait_idle();
      load_registers($urandom_range(1, 32'h00FF_FFFF), $urandom, $urandom);
      run_random(ITEMS_PER_PHASE);

      wait_idle();
      $display("%0d items sent under %0d register settings; %0d results checked.",
               points_sent, settings_used, points_checked);
      $display("%0d invalid points at the pole and %0d saturated results seen.",
               invalid_seen, saturated_seen);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Result side: random stalls, stretches of full rate, and one long hold-off
   // that lets the pipeline fill and push back on the input.
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         if (points_taken == HOLD_AT)
            gap = HOLD_CYCLES;
         else if ((points_taken / 64) % 4 == 1)
            gap = 0;
         else
            gap = $urandom_range(0, 9);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         points_taken++;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("Timed out after %0d cycles without progress.", STALL_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

endmodule
